[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on the block clock, disabled in reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/pss_pkg.sv]
package pss_pkg;
  localparam int unsigned CfgIdxBits = 3;
  localparam logic [CfgIdxBits-1:0] RegLoopLength = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegPluckOffset = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegPluckAngle = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegLevelDirect = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegLevelFeedback = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegDamp = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegDecayGain = 3'd6;
  localparam int unsigned CfgDataBits = 29;
  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef enum logic [3:0] {
    StIdle, StClear, StLdRead, StLdAng, StLdLerp, StLdComb, StLdLvl,
    StTkRead, StTkLerp, StTkInner, StTkGain, StOut, StTkMod
  } state_e;
endpackage

[rtl/plucked_string_synth.sv]
// Channel  | Handshake                  | Payload
// in       | in_valid_i / in_stall_o    | opcode_i, start_of_pluck_i, excitation_sample_i
// out      | out_valid_o / out_stall_i  | output_sample_o
// cfg      | cfg_we_i                   | cfg_index_i, cfg_data_i
// A load word goes through read, angle, interpolation, comb and level steps, or only
// the read step once the loop is full; a tick word goes through read, interpolation,
// damping and gain steps, after a modulo step when the read position lies beyond a
// shortened loop. All of this is set by the sequencer that shares one multiply-add unit
// and one memory read port. After reset a clearing pass zeroes the delay memory,
// during which no word is accepted; configuration writes are always taken.
// A finished tick waits in the output register; the next word is accepted
// only once that register is free.
module plucked_string_synth import pss_pkg::*; #(
  parameter int unsigned DELAY_DEPTH = 4096,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic                          start_of_pluck_i,
  input  logic signed [SAMPLE_BITS-1:0] excitation_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] output_sample_o,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxBits-1:0]         cfg_index_i,
  input  logic [CfgDataBits-1:0]        cfg_data_i
);
  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned SW = $clog2(AW + 1);
  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned PW = SB + 22;  // product width
  localparam logic signed [SB-1:0] SMax = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMin = {1'b1, {(SB-1){1'b0}}};
  localparam logic [LW-1:0] DepthL = LW'(DELAY_DEPTH);

  // Configuration registers.
  logic [28:0] len_q, off_q;
  logic [16:0] ang_c_q, ld_q, damp_q, gain_q;
  logic signed [17:0] lf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 29'd65536; off_q <= 29'd65536; ang_c_q <= '0;
      ld_q <= 17'd65536; lf_q <= '0; damp_q <= 17'd52429; gain_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLoopLength:    len_q <= cfg_data_i;
        RegPluckOffset:   off_q <= cfg_data_i;
        RegPluckAngle:    ang_c_q <= cfg_data_i[16:0];
        RegLevelDirect:   ld_q <= cfg_data_i[16:0];
        RegLevelFeedback: lf_q <= signed'(cfg_data_i[17:0]);
        RegDamp:          damp_q <= cfg_data_i[16:0];
        RegDecayGain:     gain_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Effective coefficients with clamping.
  function automatic logic [16:0] clamp1(input logic [16:0] v);
    return (v > 17'd65536) ? 17'd65536 : v;
  endfunction
  logic [LW-1:0] n_len;
  logic [15:0] n_fr;
  logic [16:0] p_int_w;
  logic [15:0] p_fr;
  always_comb begin
    if (len_q[28:16] == 13'd0) begin
      n_len = LW'(1); n_fr = '0;
    end else if (({16'd0, len_q[28:16]} > 29'(DELAY_DEPTH)) ||
                 (({16'd0, len_q[28:16]} == 29'(DELAY_DEPTH)) && (len_q[15:0] != 16'd0))) begin
      n_len = DepthL; n_fr = '0;
    end else begin
      n_len = LW'(len_q[28:16]); n_fr = len_q[15:0];
    end
    if (off_q[28:16] == 13'd0) begin
      p_int_w = 17'd1; p_fr = '0;
    end else begin
      p_int_w = {4'd0, off_q[28:16]}; p_fr = off_q[15:0];
    end
  end
  logic signed [17:0] a_c, ld_c, d_c, g_c, lf_c;
  assign a_c  = signed'({1'b0, clamp1(ang_c_q)});
  assign ld_c = signed'({1'b0, clamp1(ld_q)});
  assign d_c  = signed'({1'b0, clamp1(damp_q)});
  assign g_c  = signed'({1'b0, clamp1(gain_q)});
  assign lf_c = (lf_q > 18'sd65536) ? 18'sd65536 :
                (lf_q < -18'sd65536) ? -18'sd65536 : lf_q;

  // Delay memory with one registered read port.
  logic signed [SB-1:0] mem [DELAY_DEPTH];
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic signed [SB-1:0] mem_wd, mem_rd_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[mem_ra];
  end

  // Shared multiply-add: (x0*c0 + x1*c1) with x of SB+1 bits, c 19 bits.
  logic signed [SB:0] mx0, mx1;
  logic signed [18:0] mc0, mc1;
  logic signed [PW-1:0] macc;
  assign macc = PW'(mx0 * mc0) + PW'(mx1 * mc1);
  function automatic logic signed [SB-1:0] rnd(input logic signed [PW-1:0] s,
                                               input int unsigned n);
    logic signed [PW-1:0] t;
    t = (s + (PW'(1) <<< (n - 1))) >>> n;
    if (t > PW'(SMax)) return SMax;
    if (t < PW'(SMin)) return SMin;
    return t[SB-1:0];
  endfunction

  state_e st_q, st_d;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] pos_q;
  logic [LW-1:0] li_q;
  logic signed [SB-1:0] s1_q, s2_q, afm_q, lfm_q, x_q, t0_q, t1_q, y0_q, cur_q, res_q;
  logic signed [SB-1:0] out_q;
  logic ovld_q;
  logic start_q, tap_q;
  logic [AW-1:0] k_q;
  logic [LW-1:0] rem_q;
  logic [SW-1:0] sh_q;

  logic acc;
  assign in_stall_o = (st_q != StIdle) || ovld_q;
  assign acc = in_valid_i && !in_stall_o;
  assign out_valid_o = ovld_q;
  assign output_sample_o = out_q;

  // Next read position, reduced modulo the loop length by compare and subtract.
  logic [LW-1:0] pos_inc;
  assign pos_inc = {1'b0, pos_q} + LW'(1);
  logic [LW+AW-1:0] n_sh;
  assign n_sh = (LW+AW)'(n_len) << sh_q;
  logic rem_ge;
  assign rem_ge = ({{AW{1'b0}}, rem_q} >= n_sh);
  logic [AW-1:0] pos_nx;
  assign pos_nx = (rem_q >= n_len) ? '0 : rem_q[AW-1:0];
  logic [LW-1:0] li_eff;
  assign li_eff = start_q ? '0 : li_q;
  logic signed [SB:0] comb_w;
  assign comb_w = (SB+1)'(afm_q) - (SB+1)'(y0_q);
  logic signed [SB-1:0] comb_s;
  assign comb_s = (comb_w > (SB+1)'(SMax)) ? SMax :
                  (comb_w < (SB+1)'(SMin)) ? SMin : comb_w[SB-1:0];

  // Next-state and datapath control.
  always_comb begin
    st_d = st_q; mem_we = 1'b0; mem_wa = clr_q; mem_wd = '0; mem_ra = pos_q;
    mx0 = '0; mx1 = '0; mc0 = '0; mc1 = '0;
    case (st_q)
      StClear: begin
        mem_we = 1'b1;
        if (clr_q == AW'(DELAY_DEPTH - 1)) st_d = StIdle;
      end
      StIdle: if (acc) begin
        if (opcode_i == OpTick) st_d = (pos_inc > n_len) ? StTkMod : StTkRead;
        else st_d = StLdRead;
      end
      StTkMod: if (sh_q == '0) st_d = StTkRead;
      StLdRead: begin
        mem_ra = k_q;
        st_d = (li_eff >= n_len) ? StIdle : StLdAng;
      end
      StLdAng: begin
        mem_ra = AW'(k_q + AW'(1));
        mx0 = (SB+1)'(x_q); mc0 = 19'sd65536 - 19'(a_c);
        mx1 = (SB+1)'(afm_q); mc1 = 19'(a_c);
      end
      StLdLerp: begin
        mx0 = (SB+1)'(t0_q); mc0 = 19'sd65536 - 19'($signed({1'b0, p_fr}));
        mx1 = (SB+1)'((p_int_w == 17'd1) ? afm_q : mem_rd_q);
        mc1 = 19'($signed({1'b0, p_fr}));
      end
      StLdComb: ;
      StLdLvl: begin
        mx0 = (SB+1)'(comb_s); mc0 = 19'(ld_c);
        mx1 = (SB+1)'(lfm_q); mc1 = 19'(lf_c);
        mem_we = 1'b1; mem_wa = li_eff[AW-1:0]; mem_wd = rnd(macc, 16);
      end
      StTkRead: mem_ra = pos_nx;
      StTkLerp: begin
        mx0 = (SB+1)'(t0_q); mc0 = 19'sd65536 - 19'($signed({1'b0, n_fr}));
        mx1 = (SB+1)'(mem_rd_q); mc1 = 19'($signed({1'b0, n_fr}));
      end
      StTkInner: begin
        mx0 = (SB+1)'(s1_q) <<< 1; mc0 = 19'sd131072 - 19'(d_c);
        mx1 = (SB+1)'(cur_q) + (SB+1)'(s2_q); mc1 = 19'(d_c);
      end
      StTkGain: begin
        mx0 = (SB+1)'(res_q); mc0 = 19'(g_c);
        mem_we = 1'b1; mem_wa = pos_q; mem_wd = rnd(macc, 16);
      end
      default: st_d = StIdle;
    endcase
    case (st_q)
      StLdAng: st_d = StLdLerp;
      StLdLerp: st_d = StLdComb;
      StLdComb: st_d = StLdLvl;
      StLdLvl, StTkGain: st_d = StIdle;
      StTkLerp: st_d = StTkInner;
      StTkInner: st_d = StTkGain;
      StTkRead: st_d = StTkLerp;
      default: ;
    endcase
  end

  // Sequencer and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; clr_q <= '0; pos_q <= '0; li_q <= '0;
      s1_q <= '0; s2_q <= '0; afm_q <= '0; lfm_q <= '0; ovld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StClear) clr_q <= AW'(clr_q + AW'(1));
      if (ovld_q && !out_stall_i) ovld_q <= 1'b0;
      case (st_q)
        StLdRead: if (start_q) begin
          afm_q <= '0; lfm_q <= '0; li_q <= '0;
        end
        StLdAng: afm_q <= rnd(macc, 16);
        StLdLvl: begin
          lfm_q <= rnd(macc, 16); li_q <= li_eff + LW'(1);
        end
        StTkGain: begin
          s2_q <= s1_q; s1_q <= cur_q; pos_q <= pos_nx;
          ovld_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      x_q <= excitation_sample_i; start_q <= start_of_pluck_i;
      k_q <= AW'((start_of_pluck_i ? '0 : li_q) - LW'(p_int_w));
      rem_q <= pos_inc; sh_q <= SW'(AW);
    end
    case (st_q)
      StTkMod: begin
        if (rem_ge) rem_q <= rem_q - n_sh[LW-1:0];
        sh_q <= sh_q - SW'(1);
      end
      StLdRead: tap_q <= (17'(li_eff) >= p_int_w);
      StLdAng: t0_q <= mem_rd_q;
      StLdLerp: y0_q <= tap_q ? rnd(macc, 16) : '0;
      StTkRead: t0_q <= mem_rd_q;
      StTkLerp: begin cur_q <= rnd(macc, 16); out_q <= rnd(macc, 16); end
      StTkInner: res_q <= rnd(macc, 18);
      default: ;
    endcase
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_no_accept_busy, !(acc && (st_q != StIdle)))
  `ASSERT_NEXT(a_tick_out, st_q == StTkGain, out_valid_o)
  `ASSERT_CLK(a_pos_range, {1'b0, pos_q} < DepthL)
endmodule
